// File: src/hsps_pkg.sv
// Shared types, constants and helper functions for the SPS header parser.
// No dependencies; read before hsps_ctrl, hsps_dp, the top level and the testbench.
`default_nettype none
package hsps_pkg;

  localparam int unsigned MAX_BLOCKS_DIM = 1024;
  localparam int unsigned MAX_CODE_BITS  = 32;
  localparam int unsigned MAX_CYCLE_REFS = 255;
  localparam int unsigned CROP_LIMIT     = 4095;
  localparam logic [4:0]  NAL_TYPE_SPS   = 5'd7;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_SPS  = 2'd1;
  localparam logic [1:0] ST_NO_BITS  = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // syntax element being parsed, one-hot
  typedef enum logic [34:0] {
    PH_HDR    = 35'h1 << 0,
    PH_PROF   = 35'h1 << 1,
    PH_CONS   = 35'h1 << 2,
    PH_LEVEL  = 35'h1 << 3,
    PH_ID     = 35'h1 << 4,
    PH_CHROMA = 35'h1 << 5,
    PH_SEP    = 35'h1 << 6,
    PH_BDL    = 35'h1 << 7,
    PH_BDC    = 35'h1 << 8,
    PH_BYP    = 35'h1 << 9,
    PH_SMF    = 35'h1 << 10,
    PH_LISTF  = 35'h1 << 11,
    PH_DELTA  = 35'h1 << 12,
    PH_LOG2FN = 35'h1 << 13,
    PH_POCT   = 35'h1 << 14,
    PH_POCLSB = 35'h1 << 15,
    PH_DPOZ   = 35'h1 << 16,
    PH_OFFNR  = 35'h1 << 17,
    PH_OFFTB  = 35'h1 << 18,
    PH_NCYC   = 35'h1 << 19,
    PH_OFFREF = 35'h1 << 20,
    PH_NREF   = 35'h1 << 21,
    PH_GAPS   = 35'h1 << 22,
    PH_WID    = 35'h1 << 23,
    PH_HGT    = 35'h1 << 24,
    PH_FMO    = 35'h1 << 25,
    PH_MBAFF  = 35'h1 << 26,
    PH_D8     = 35'h1 << 27,
    PH_CROPF  = 35'h1 << 28,
    PH_CL     = 35'h1 << 29,
    PH_CR     = 35'h1 << 30,
    PH_CT     = 35'h1 << 31,
    PH_CB     = 35'h1 << 32,
    PH_DONE   = 35'h1 << 33,
    PH_ERR    = 35'h1 << 34
  } ph_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // take a new byte into the bit shifter
    logic step;    // consume one bit
    logic finish;  // capture the result and rearm
  } hsps_cmd_t;

  // fixed field width of a syntax element; 0 means Exp-Golomb coded
  function automatic logic [3:0] ph_width(input ph_t p);
    logic [3:0] w;
    begin
      w = 4'd0;
      unique case (p)
        PH_HDR, PH_PROF, PH_CONS, PH_LEVEL: w = 4'd8;
        PH_SEP, PH_BYP, PH_SMF, PH_LISTF, PH_DPOZ, PH_GAPS,
        PH_FMO, PH_MBAFF, PH_D8, PH_CROPF: w = 4'd1;
        default: w = 4'd0;
      endcase
      return w;
    end
  endfunction

  // profiles that carry chroma format, bit depth and scaling lists
  function automatic logic high_profile(input logic [7:0] p);
    return (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244) ||
           (p == 8'd44)  || (p == 8'd83)  || (p == 8'd86)  || (p == 8'd118) ||
           (p == 8'd128) || (p == 8'd138) || (p == 8'd139) || (p == 8'd134);
  endfunction

endpackage
`default_nettype wire

// File: src/hsps_if.sv
// Valid/ready channel interfaces for the SPS parser's input and result streams.
// Depends on nothing.
`default_nettype none
interface hsps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface hsps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  profile_code;
  logic [7:0]  constraint_flags;
  logic [7:0]  level_code;
  logic [4:0]  sps_id;
  logic [1:0]  chroma_format;
  logic [3:0]  luma_bit_depth;
  logic [3:0]  chroma_bit_depth;
  logic [4:0]  log2_max_frame_num;
  logic [4:0]  ref_frame_count;
  logic [14:0] frame_width;
  logic [15:0] frame_height;
  modport source (output valid, output status, output profile_code,
                  output constraint_flags, output level_code, output sps_id,
                  output chroma_format, output luma_bit_depth,
                  output chroma_bit_depth, output log2_max_frame_num,
                  output ref_frame_count, output frame_width,
                  output frame_height, input ready);
  modport sink   (input valid, input status, input profile_code,
                  input constraint_flags, input level_code, input sps_id,
                  input chroma_format, input luma_bit_depth,
                  input chroma_bit_depth, input log2_max_frame_num,
                  input ref_frame_count, input frame_width,
                  input frame_height, output ready);
endinterface
`default_nettype wire

// File: src/hsps_ctrl.sv
// Sequencer for the SPS parser: byte handshake, bit count, result transfer.
// Depends on hsps_pkg.
`default_nettype none
module hsps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hsps_pkg::hsps_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } st_t;

  st_t        state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic       oval_r, oval_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    oval_nxt   = oval_r && !out_ready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last;
          cnt_nxt   = 3'd0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // wait until the result register is free
        if (!oval_r || out_ready) begin
          cmd.finish = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      last_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/hsps_dp.sv
// Bit-serial SPS datapath: bit shifter, Exp-Golomb decoder, field registers,
// bound checks and result register. Depends on hsps_pkg.
`default_nettype none
module hsps_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hsps_pkg::hsps_cmd_t cmd,
  input  wire logic [7:0]        in_byte,
  output logic [1:0]             res_status,
  output logic [7:0]             res_profile,
  output logic [7:0]             res_cons,
  output logic [7:0]             res_level,
  output logic [4:0]             res_id,
  output logic [1:0]             res_cf,
  output logic [3:0]             res_lbd,
  output logic [3:0]             res_cbd,
  output logic [4:0]             res_log2,
  output logic [4:0]             res_refs,
  output logic [14:0]            res_width,
  output logic [15:0]            res_height
);

  hsps_pkg::ph_t ph_r, ph_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [5:0]  cb_r, cb_nxt;
  logic [5:0]  zr_r, zr_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  loop_r, loop_nxt;
  logic [3:0]  lidx_r, lidx_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  upc_r, upc_nxt;
  logic [7:0]  prof_r, prof_nxt, cons_r, cons_nxt, lvl_r, lvl_nxt;
  logic [4:0]  id_r, id_nxt;
  logic [1:0]  cf_r, cf_nxt;
  logic [3:0]  lbd_r, lbd_nxt, cbd_r, cbd_nxt;
  logic [4:0]  log2_r, log2_nxt, refs_r, refs_nxt;
  logic        fmo_r, fmo_nxt;
  logic [10:0] wmb_r, wmb_nxt, hmb_r, hmb_nxt;
  logic [11:0] crop_r [4];
  logic [11:0] crop_nxt [4];
  logic [1:0]  err_r, err_nxt;

  logic        bit_in;
  logic [3:0]  fw;
  logic        take;
  logic [31:0] v;
  logic [31:0] acc_sh;
  logic [7:0]  dlt, upc_d, loop_inc, loop_dec;
  logic [6:0]  lsize;
  logic [3:0]  lidx_inc, lcount;
  logic [12:0] wsum_c, hsum_c;
  logic [14:0] fw_full;
  logic [15:0] fh_full;

  assign bit_in   = sh_r[7];
  assign fw       = hsps_pkg::ph_width(ph_r);
  assign acc_sh   = {acc_r[30:0], bit_in};
  assign lsize    = (lidx_r < 4'd6) ? 7'd16 : 7'd64;
  assign lcount   = (cf_r == 2'd3) ? 4'd12 : 4'd8;
  assign lidx_inc = lidx_r + 4'd1;
  assign loop_inc = loop_r + 8'd1;
  assign loop_dec = (loop_r != 8'd0) ? loop_r - 8'd1 : 8'd0;

  // uncropped picture size in luma samples
  assign fw_full = {wmb_r, 4'b0000};
  assign fh_full = fmo_r ? {1'b0, hmb_r, 4'b0000} : {hmb_r, 5'b00000};

  // one bit of parsing per step
  always_comb begin
    ph_nxt   = ph_r;
    sh_nxt   = sh_r;
    cb_nxt   = cb_r;
    zr_nxt   = zr_r;
    acc_nxt  = acc_r;
    loop_nxt = loop_r;
    lidx_nxt = lidx_r;
    prev_nxt = prev_r;
    upc_nxt  = upc_r;
    prof_nxt = prof_r;
    cons_nxt = cons_r;
    lvl_nxt  = lvl_r;
    id_nxt   = id_r;
    cf_nxt   = cf_r;
    lbd_nxt  = lbd_r;
    cbd_nxt  = cbd_r;
    log2_nxt = log2_r;
    refs_nxt = refs_r;
    fmo_nxt  = fmo_r;
    wmb_nxt  = wmb_r;
    hmb_nxt  = hmb_r;
    crop_nxt = crop_r;
    err_nxt  = err_r;
    take     = 1'b0;
    v        = 32'd0;
    dlt      = 8'd0;
    upc_d    = 8'd0;
    wsum_c   = 13'd0;
    hsum_c   = 13'd0;

    if (cmd.load) begin
      sh_nxt = in_byte;
    end

    if (cmd.step) begin
      sh_nxt = {sh_r[6:0], 1'b0};
      if (ph_r == hsps_pkg::PH_DONE || ph_r == hsps_pkg::PH_ERR) begin
        // trailing bits are ignored
      end else if (fw != 4'd0) begin
        // fixed-width field
        acc_nxt = acc_sh;
        cb_nxt  = cb_r + 6'd1;
        if (cb_r + 6'd1 >= {2'b00, fw}) begin
          v       = acc_sh;
          acc_nxt = 32'd0;
          cb_nxt  = 6'd0;
          take    = 1'b1;
        end
      end else if (cb_r == 6'd0) begin
        // Exp-Golomb prefix
        if (!bit_in) begin
          zr_nxt = zr_r + 6'd1;
          if (zr_r + 6'd1 >= 6'(hsps_pkg::MAX_CODE_BITS)) begin
            err_nxt = hsps_pkg::ST_RANGE;
            ph_nxt  = hsps_pkg::PH_ERR;
          end
        end else if (zr_r == 6'd0) begin
          take = 1'b1;
        end else begin
          cb_nxt  = zr_r;
          acc_nxt = 32'd1;  // leading one: accumulator holds value plus one
        end
      end else begin
        // Exp-Golomb suffix
        acc_nxt = acc_sh;
        cb_nxt  = cb_r - 6'd1;
        if (cb_r == 6'd1) begin
          v       = acc_sh - 32'd1;
          zr_nxt  = 6'd0;
          acc_nxt = 32'd0;
          take    = 1'b1;
        end
      end

      // act on a completed syntax element
      if (take) begin
        unique case (ph_r)
          hsps_pkg::PH_HDR: begin
            if (v[4:0] != hsps_pkg::NAL_TYPE_SPS) begin
              err_nxt = hsps_pkg::ST_NOT_SPS; ph_nxt = hsps_pkg::PH_ERR;
            end else ph_nxt = hsps_pkg::PH_PROF;
          end
          hsps_pkg::PH_PROF:  begin prof_nxt = v[7:0]; ph_nxt = hsps_pkg::PH_CONS; end
          hsps_pkg::PH_CONS:  begin cons_nxt = v[7:0]; ph_nxt = hsps_pkg::PH_LEVEL; end
          hsps_pkg::PH_LEVEL: begin lvl_nxt = v[7:0]; ph_nxt = hsps_pkg::PH_ID; end
          hsps_pkg::PH_ID: begin
            if (v > 32'd31) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              id_nxt = v[4:0];
              ph_nxt = hsps_pkg::high_profile(prof_r) ? hsps_pkg::PH_CHROMA
                                                      : hsps_pkg::PH_LOG2FN;
            end
          end
          hsps_pkg::PH_CHROMA: begin
            if (v > 32'd3) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              cf_nxt = v[1:0];
              ph_nxt = (v[1:0] == 2'd3) ? hsps_pkg::PH_SEP : hsps_pkg::PH_BDL;
            end
          end
          hsps_pkg::PH_SEP: ph_nxt = hsps_pkg::PH_BDL;
          hsps_pkg::PH_BDL: begin
            if (v > 32'd6) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              lbd_nxt = v[3:0] + 4'd8; ph_nxt = hsps_pkg::PH_BDC;
            end
          end
          hsps_pkg::PH_BDC: begin
            if (v > 32'd6) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              cbd_nxt = v[3:0] + 4'd8; ph_nxt = hsps_pkg::PH_BYP;
            end
          end
          hsps_pkg::PH_BYP: ph_nxt = hsps_pkg::PH_SMF;
          hsps_pkg::PH_SMF: begin
            lidx_nxt = 4'd0;
            ph_nxt   = v[0] ? hsps_pkg::PH_LISTF : hsps_pkg::PH_LOG2FN;
          end
          hsps_pkg::PH_LISTF: begin
            // list present: walk its deltas; absent: next list
            loop_nxt = 8'd0;
            prev_nxt = 8'd8;
            upc_nxt  = 8'd8;
            if (v[0]) begin
              ph_nxt = hsps_pkg::PH_DELTA;
            end else begin
              lidx_nxt = lidx_inc;
              ph_nxt   = (lidx_inc < lcount) ? hsps_pkg::PH_LISTF
                                             : hsps_pkg::PH_LOG2FN;
            end
          end
          hsps_pkg::PH_DELTA: begin
            dlt      = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
            upc_d    = prev_r + dlt;
            loop_nxt = loop_inc;
            if (loop_inc < {1'b0, lsize} && upc_d != 8'd0) begin
              upc_nxt = upc_d;
              prev_nxt = upc_d;
            end else begin
              prev_nxt = 8'd8;
              upc_nxt  = 8'd8;
              lidx_nxt = lidx_inc;
              ph_nxt   = (lidx_inc < lcount) ? hsps_pkg::PH_LISTF
                                             : hsps_pkg::PH_LOG2FN;
            end
          end
          hsps_pkg::PH_LOG2FN: begin
            if (v > 32'd12) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              log2_nxt = v[4:0] + 5'd4; ph_nxt = hsps_pkg::PH_POCT;
            end
          end
          hsps_pkg::PH_POCT: begin
            if (v > 32'd2) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else if (v[1:0] == 2'd0) ph_nxt = hsps_pkg::PH_POCLSB;
            else if (v[1:0] == 2'd1) ph_nxt = hsps_pkg::PH_DPOZ;
            else ph_nxt = hsps_pkg::PH_NREF;
          end
          hsps_pkg::PH_POCLSB: begin
            if (v > 32'd12) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else ph_nxt = hsps_pkg::PH_NREF;
          end
          hsps_pkg::PH_DPOZ:  ph_nxt = hsps_pkg::PH_OFFNR;
          hsps_pkg::PH_OFFNR: ph_nxt = hsps_pkg::PH_OFFTB;
          hsps_pkg::PH_OFFTB: ph_nxt = hsps_pkg::PH_NCYC;
          hsps_pkg::PH_NCYC: begin
            if (v > 32'(hsps_pkg::MAX_CYCLE_REFS)) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              loop_nxt = v[7:0];
              ph_nxt   = (v[7:0] == 8'd0) ? hsps_pkg::PH_NREF : hsps_pkg::PH_OFFREF;
            end
          end
          hsps_pkg::PH_OFFREF: begin
            loop_nxt = loop_dec;
            if (loop_dec == 8'd0) ph_nxt = hsps_pkg::PH_NREF;
          end
          hsps_pkg::PH_NREF: begin
            if (v > 32'd16) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              refs_nxt = v[4:0]; ph_nxt = hsps_pkg::PH_GAPS;
            end
          end
          hsps_pkg::PH_GAPS: ph_nxt = hsps_pkg::PH_WID;
          hsps_pkg::PH_WID: begin
            if (v > 32'(hsps_pkg::MAX_BLOCKS_DIM - 1)) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              wmb_nxt = v[10:0] + 11'd1; ph_nxt = hsps_pkg::PH_HGT;
            end
          end
          hsps_pkg::PH_HGT: begin
            if (v > 32'(hsps_pkg::MAX_BLOCKS_DIM - 1)) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              hmb_nxt = v[10:0] + 11'd1; ph_nxt = hsps_pkg::PH_FMO;
            end
          end
          hsps_pkg::PH_FMO: begin
            fmo_nxt = v[0];
            ph_nxt  = v[0] ? hsps_pkg::PH_D8 : hsps_pkg::PH_MBAFF;
          end
          hsps_pkg::PH_MBAFF: ph_nxt = hsps_pkg::PH_D8;
          hsps_pkg::PH_D8:    ph_nxt = hsps_pkg::PH_CROPF;
          hsps_pkg::PH_CROPF: ph_nxt = v[0] ? hsps_pkg::PH_CL : hsps_pkg::PH_DONE;
          hsps_pkg::PH_CL, hsps_pkg::PH_CR, hsps_pkg::PH_CT: begin
            if (v > 32'(hsps_pkg::CROP_LIMIT)) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else if (ph_r == hsps_pkg::PH_CL) begin
              crop_nxt[0] = v[11:0]; ph_nxt = hsps_pkg::PH_CR;
            end else if (ph_r == hsps_pkg::PH_CR) begin
              crop_nxt[1] = v[11:0]; ph_nxt = hsps_pkg::PH_CT;
            end else begin
              crop_nxt[2] = v[11:0]; ph_nxt = hsps_pkg::PH_CB;
            end
          end
          hsps_pkg::PH_CB: begin
            // last offset, then cropping must fit inside the picture
            wsum_c = {1'b0, crop_r[0]} + {1'b0, crop_r[1]};
            hsum_c = {1'b0, crop_r[2]} + {1'b0, v[11:0]};
            if (v > 32'(hsps_pkg::CROP_LIMIT)) begin
              err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
            end else begin
              crop_nxt[3] = v[11:0];
              if ({1'b0, wsum_c, 1'b0} > fw_full ||
                  {2'b00, hsum_c, 1'b0} > fh_full) begin
                err_nxt = hsps_pkg::ST_RANGE; ph_nxt = hsps_pkg::PH_ERR;
              end else ph_nxt = hsps_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // parse state, cleared at reset and after each result
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      ph_r   <= hsps_pkg::PH_HDR;
      cb_r   <= 6'd0;
      zr_r   <= 6'd0;
      acc_r  <= 32'd0;
      loop_r <= 8'd0;
      lidx_r <= 4'd0;
      prev_r <= 8'd8;
      upc_r  <= 8'd8;
      prof_r <= 8'd0;
      cons_r <= 8'd0;
      lvl_r  <= 8'd0;
      id_r   <= 5'd0;
      cf_r   <= 2'd1;
      lbd_r  <= 4'd8;
      cbd_r  <= 4'd8;
      log2_r <= 5'd0;
      refs_r <= 5'd0;
      fmo_r  <= 1'b0;
      wmb_r  <= 11'd0;
      hmb_r  <= 11'd0;
      for (int i = 0; i < 4; i++) crop_r[i] <= 12'd0;
      err_r  <= 2'd0;
    end else begin
      ph_r   <= ph_nxt;
      cb_r   <= cb_nxt;
      zr_r   <= zr_nxt;
      acc_r  <= acc_nxt;
      loop_r <= loop_nxt;
      lidx_r <= lidx_nxt;
      prev_r <= prev_nxt;
      upc_r  <= upc_nxt;
      prof_r <= prof_nxt;
      cons_r <= cons_nxt;
      lvl_r  <= lvl_nxt;
      id_r   <= id_nxt;
      cf_r   <= cf_nxt;
      lbd_r  <= lbd_nxt;
      cbd_r  <= cbd_nxt;
      log2_r <= log2_nxt;
      refs_r <= refs_nxt;
      fmo_r  <= fmo_nxt;
      wmb_r  <= wmb_nxt;
      hmb_r  <= hmb_nxt;
      crop_r <= crop_nxt;
      err_r  <= err_nxt;
    end
  end

  // bit shifter holds payload only
  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  // result register, loaded when the controller finishes a NAL unit
  logic [1:0]  st_fin;
  logic        ok_fin;
  logic [12:0] wsum_fin, hsum_fin;

  assign wsum_fin = {1'b0, crop_r[0]} + {1'b0, crop_r[1]};
  assign hsum_fin = {1'b0, crop_r[2]} + {1'b0, crop_r[3]};
  assign st_fin = (ph_r == hsps_pkg::PH_ERR)  ? err_r :
                  (ph_r == hsps_pkg::PH_DONE) ? hsps_pkg::ST_OK : hsps_pkg::ST_NO_BITS;
  assign ok_fin = (st_fin == hsps_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status  <= st_fin;
      res_profile <= ok_fin ? prof_r : 8'd0;
      res_cons    <= ok_fin ? cons_r : 8'd0;
      res_level   <= ok_fin ? lvl_r : 8'd0;
      res_id      <= ok_fin ? id_r : 5'd0;
      res_cf      <= ok_fin ? cf_r : 2'd0;
      res_lbd     <= ok_fin ? lbd_r : 4'd0;
      res_cbd     <= ok_fin ? cbd_r : 4'd0;
      res_log2    <= ok_fin ? log2_r : 5'd0;
      res_refs    <= ok_fin ? refs_r : 5'd0;
      res_width   <= ok_fin ? fw_full - {1'b0, wsum_fin, 1'b0} : 15'd0;
      res_height  <= ok_fin ? fh_full - {2'b00, hsum_fin, 1'b0} : 16'd0;
    end
  end

endmodule
`default_nettype wire

// File: src/h264_sps_header_parser.sv
// H.264 SPS header parser, top level: joins the sequencer and the datapath.
// Depends on hsps_pkg, hsps_if, hsps_ctrl and hsps_dp.
//
// Takes one SPS NAL byte per transfer (emulation-prevention bytes already
// removed, header byte first, last byte marked) and parses it one bit per
// clock. A byte is taken only in the idle state, and no new byte is taken
// until the bit-serial decoder has shifted out all its bits. After the last
// byte of a NAL the finish state loads the result register; a result that
// waits there does not block the bytes that follow, but the last byte of the
// next NAL stalls until it has been taken. Exactly one result comes out
// per NAL: status (ok, not an SPS, ran out of bits, value out of range),
// the header and format fields, and the cropped picture size. On any error
// every other result field is zero.
`default_nettype none
module h264_sps_header_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsps_in_if.sink    in_chan,
  hsps_out_if.source out_chan
);

  hsps_pkg::hsps_cmd_t cmd;

  hsps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_last   (in_chan.last_byte),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  hsps_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_chan.byte_value),
    .res_status  (out_chan.status),
    .res_profile (out_chan.profile_code),
    .res_cons    (out_chan.constraint_flags),
    .res_level   (out_chan.level_code),
    .res_id      (out_chan.sps_id),
    .res_cf      (out_chan.chroma_format),
    .res_lbd     (out_chan.luma_bit_depth),
    .res_cbd     (out_chan.chroma_bit_depth),
    .res_log2    (out_chan.log2_max_frame_num),
    .res_refs    (out_chan.ref_frame_count),
    .res_width   (out_chan.frame_width),
    .res_height  (out_chan.frame_height)
  );

endmodule
`default_nettype wire

// File: dv/h264_sps_header_parser_tb.sv
// Testbench for h264_sps_header_parser: builds SPS bitstreams, drives them bytewise
// and checks each result against a bit-serial predictor kept in this file.
// Depends on hsps_pkg, hsps_if and the RTL top level.
`default_nettype none
module h264_sps_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned QUIET_TAIL  = 60;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  profile_code;
    logic [7:0]  constraint_flags;
    logic [7:0]  level_code;
    logic [4:0]  sps_id;
    logic [1:0]  chroma_format;
    logic [3:0]  luma_bit_depth;
    logic [3:0]  chroma_bit_depth;
    logic [4:0]  log2_max_frame_num;
    logic [4:0]  ref_frame_count;
    logic [14:0] frame_width;
    logic [15:0] frame_height;
  } sps_result_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } nal_byte_t;

  logic clk;
  logic rst_n;

  hsps_in_if  in_chan();
  hsps_out_if out_chan();

  h264_sps_header_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // SPS parse predictor
  // ---------------------------------------------------------------------------
  ph_t         sp_phase;
  int unsigned sp_nbits;
  int unsigned sp_zeros;
  logic [63:0] sp_accum;
  int unsigned sp_loops;
  int unsigned sp_list;
  int unsigned sp_prev_scale;
  int unsigned sp_next_scale;
  int unsigned sp_profile, sp_cons, sp_level;
  int unsigned sp_id, sp_cf, sp_lbd, sp_cbd, sp_log2fn, sp_refs, sp_fmo;
  int unsigned sp_wblk, sp_hblk;
  int unsigned sp_crop[4];
  int unsigned sp_err;

  sps_result_t expected_results[$];

  task automatic sps_clear();
    sp_phase = PH_HDR;
    sp_nbits = 0;
    sp_zeros = 0;
    sp_accum = '0;
    sp_loops = 0;
    sp_list = 0;
    sp_prev_scale = 8;
    sp_next_scale = 8;
    sp_profile = 0; sp_cons = 0; sp_level = 0;
    sp_id = 0; sp_cf = 1; sp_lbd = 8; sp_cbd = 8;
    sp_log2fn = 0; sp_refs = 0; sp_fmo = 0;
    sp_wblk = 0; sp_hblk = 0;
    foreach (sp_crop[i]) sp_crop[i] = 0;
    sp_err = 0;
  endtask

  function automatic bit is_high_profile(int unsigned p);
    return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 || p == 83 ||
           p == 86 || p == 118 || p == 128 || p == 138 || p == 139 || p == 134;
  endfunction

  // fixed-length field size per element; 0 for Exp-Golomb elements
  function automatic int unsigned elem_bits(ph_t p);
    case (p)
      PH_HDR, PH_PROF, PH_CONS, PH_LEVEL: return 8;
      PH_SEP, PH_BYP, PH_SMF, PH_LISTF, PH_DPOZ, PH_GAPS,
      PH_FMO, PH_MBAFF, PH_D8, PH_CROPF: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic sps_fail(int unsigned code);
    sp_err = code;
    sp_phase = PH_ERR;
  endtask

  // next delta inside the current scaling list, or the next list
  task automatic scaling_step();
    int unsigned size;
    int unsigned count;
    size = (sp_list < 6) ? 16 : 64;
    count = (sp_cf == 3) ? 12 : 8;
    if (sp_loops < size && sp_next_scale != 0) begin
      sp_phase = PH_DELTA;
    end else begin
      sp_list++;
      sp_phase = (sp_list < count) ? PH_LISTF : PH_LOG2FN;
    end
  endtask

  // decoded values never exceed 2^32 - 2, so 32 bits hold them
  task automatic take_element(int unsigned v);
    int unsigned d;
    int unsigned w_px, h_px;
    case (sp_phase)
      PH_HDR: begin
        if (v[4:0] != NAL_TYPE_SPS) sps_fail(ST_NOT_SPS);
        else sp_phase = PH_PROF;
      end
      PH_PROF: begin sp_profile = v; sp_phase = PH_CONS; end
      PH_CONS: begin sp_cons = v; sp_phase = PH_LEVEL; end
      PH_LEVEL: begin sp_level = v; sp_phase = PH_ID; end
      PH_ID: begin
        if (v > 31) sps_fail(ST_RANGE);
        else begin
          sp_id = v;
          sp_phase = is_high_profile(sp_profile) ? PH_CHROMA : PH_LOG2FN;
        end
      end
      PH_CHROMA: begin
        if (v > 3) sps_fail(ST_RANGE);
        else begin
          sp_cf = v;
          sp_phase = (v == 3) ? PH_SEP : PH_BDL;
        end
      end
      PH_SEP: sp_phase = PH_BDL;
      PH_BDL: begin
        if (v > 6) sps_fail(ST_RANGE);
        else begin sp_lbd = v + 8; sp_phase = PH_BDC; end
      end
      PH_BDC: begin
        if (v > 6) sps_fail(ST_RANGE);
        else begin sp_cbd = v + 8; sp_phase = PH_BYP; end
      end
      PH_BYP: sp_phase = PH_SMF;
      PH_SMF: begin
        sp_list = 0;
        sp_phase = (v != 0) ? PH_LISTF : PH_LOG2FN;
      end
      PH_LISTF: begin
        sp_loops = 0;
        sp_prev_scale = 8;
        sp_next_scale = (v != 0) ? 8 : 0;
        scaling_step();
        if (v == 0) begin sp_prev_scale = 8; sp_next_scale = 8; end
      end
      PH_DELTA: begin
        d = v[0] ? ((v + 1) >> 1) : (32'd0 - (v >> 1));
        sp_next_scale = (sp_prev_scale + d) & 32'hff;
        if (sp_next_scale != 0) sp_prev_scale = sp_next_scale;
        sp_loops++;
        scaling_step();
        if (sp_phase != PH_DELTA) begin sp_prev_scale = 8; sp_next_scale = 8; end
      end
      PH_LOG2FN: begin
        if (v > 12) sps_fail(ST_RANGE);
        else begin sp_log2fn = v + 4; sp_phase = PH_POCT; end
      end
      PH_POCT: begin
        if (v > 2) sps_fail(ST_RANGE);
        else sp_phase = (v == 0) ? PH_POCLSB : (v == 1) ? PH_DPOZ : PH_NREF;
      end
      PH_POCLSB: begin
        if (v > 12) sps_fail(ST_RANGE);
        else sp_phase = PH_NREF;
      end
      PH_DPOZ: sp_phase = PH_OFFNR;
      PH_OFFNR: sp_phase = PH_OFFTB;
      PH_OFFTB: sp_phase = PH_NCYC;
      PH_NCYC: begin
        if (v > MAX_CYCLE_REFS) sps_fail(ST_RANGE);
        else begin
          sp_loops = v;
          sp_phase = (v == 0) ? PH_NREF : PH_OFFREF;
        end
      end
      PH_OFFREF: begin
        if (sp_loops > 0) sp_loops--;
        if (sp_loops == 0) sp_phase = PH_NREF;
      end
      PH_NREF: begin
        if (v > 16) sps_fail(ST_RANGE);
        else begin sp_refs = v; sp_phase = PH_GAPS; end
      end
      PH_GAPS: sp_phase = PH_WID;
      PH_WID: begin
        if (v + 1 > MAX_BLOCKS_DIM) sps_fail(ST_RANGE);
        else begin sp_wblk = v + 1; sp_phase = PH_HGT; end
      end
      PH_HGT: begin
        if (v + 1 > MAX_BLOCKS_DIM) sps_fail(ST_RANGE);
        else begin sp_hblk = v + 1; sp_phase = PH_FMO; end
      end
      PH_FMO: begin
        sp_fmo = 32'(v[0]);
        sp_phase = (v != 0) ? PH_D8 : PH_MBAFF;
      end
      PH_MBAFF: sp_phase = PH_D8;
      PH_D8: sp_phase = PH_CROPF;
      PH_CROPF: sp_phase = (v != 0) ? PH_CL : PH_DONE;
      PH_CL, PH_CR, PH_CT, PH_CB: begin
        if (v > CROP_LIMIT) sps_fail(ST_RANGE);
        else begin
          case (sp_phase)
            PH_CL: begin sp_crop[0] = v; sp_phase = PH_CR; end
            PH_CR: begin sp_crop[1] = v; sp_phase = PH_CT; end
            PH_CT: begin sp_crop[2] = v; sp_phase = PH_CB; end
            default: begin
              sp_crop[3] = v;
              w_px = sp_wblk * 16;
              h_px = (2 - sp_fmo) * sp_hblk * 16;
              if ((sp_crop[0] + sp_crop[1]) * 2 > w_px ||
                  (sp_crop[2] + sp_crop[3]) * 2 > h_px) sps_fail(ST_RANGE);
              else sp_phase = PH_DONE;
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic consume_bit(bit b);
    logic [63:0] v;
    if (sp_phase == PH_DONE || sp_phase == PH_ERR) return;
    if (elem_bits(sp_phase) != 0) begin
      sp_accum = (sp_accum << 1) | b;
      sp_nbits++;
      if (sp_nbits >= elem_bits(sp_phase)) begin
        v = sp_accum;
        sp_accum = '0;
        sp_nbits = 0;
        take_element(v[31:0]);
      end
      return;
    end
    // Exp-Golomb: count leading zeros, then read that many info bits
    if (sp_nbits == 0) begin
      if (!b) begin
        sp_zeros++;
        if (sp_zeros >= MAX_CODE_BITS) sps_fail(ST_RANGE);
      end else if (sp_zeros == 0) begin
        take_element(32'd0);
      end else begin
        sp_nbits = sp_zeros;
        sp_accum = '0;
      end
      return;
    end
    sp_accum = (sp_accum << 1) | b;
    sp_nbits--;
    if (sp_nbits == 0) begin
      v = ((64'd1 << (sp_zeros & 31)) - 1) + sp_accum;
      sp_zeros = 0;
      sp_accum = '0;
      take_element(v[31:0]);
    end
  endtask

  task automatic predict_byte(nal_byte_t nb);
    sps_result_t r;
    for (int k = 7; k >= 0; k--) consume_bit(nb.byte_value[k]);
    if (!nb.last_byte) return;
    r = '0;
    if (sp_phase == PH_ERR) r.status = sp_err[1:0];
    else if (sp_phase != PH_DONE) r.status = ST_NO_BITS;
    else r.status = ST_OK;
    if (r.status == ST_OK) begin
      r.profile_code = sp_profile[7:0];
      r.constraint_flags = sp_cons[7:0];
      r.level_code = sp_level[7:0];
      r.sps_id = sp_id[4:0];
      r.chroma_format = sp_cf[1:0];
      r.luma_bit_depth = sp_lbd[3:0];
      r.chroma_bit_depth = sp_cbd[3:0];
      r.log2_max_frame_num = sp_log2fn[4:0];
      r.ref_frame_count = sp_refs[4:0];
      r.frame_width = 15'(sp_wblk * 16 - (sp_crop[0] + sp_crop[1]) * 2);
      r.frame_height = 16'((2 - sp_fmo) * sp_hblk * 16 - (sp_crop[2] + sp_crop[3]) * 2);
    end
    expected_results.push_back(r);
    sps_clear();
  endtask

  // ---------------------------------------------------------------------------
  // Bitstream builder
  // ---------------------------------------------------------------------------
  bit        nal_bits[$];
  nal_byte_t pending_bytes[$];

  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned x;
    int n;
    x = v + 1;
    n = 0;
    while ((x >> n) != 0) n++;
    put_bits(0, n - 1);
    put_bits(x, n);
  endtask

  task automatic put_se(int v);
    put_ue(v > 0 ? 2 * v - 1 : -2 * v);
  endtask

  // ends the current NAL: rbsp stop bit, optional truncation or extra bytes
  task automatic close_nal(int cut_bits, int extra_bytes);
    int nbytes;
    nal_byte_t nb;
    nal_bits.push_back(1'b1);
    while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'b0);
    for (int i = 0; i < cut_bits && nal_bits.size() > 8; i++) void'(nal_bits.pop_back());
    while (nal_bits.size() % 8 != 0) nal_bits.push_back($urandom_range(0, 1));
    for (int i = 0; i < extra_bytes; i++) put_bits($urandom_range(0, 255), 8);
    nbytes = nal_bits.size() / 8;
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++) nb.byte_value[7 - k] = nal_bits[8 * i + k];
      nb.last_byte = (i == nbytes - 1);
      pending_bytes.push_back(nb);
    end
    nal_bits.delete();
  endtask

  // Exp-Golomb value mostly in range, now and then just past it
  function automatic longint unsigned pick_ue(int unsigned hi, int unsigned spill_pct);
    if ($urandom_range(1, 100) <= spill_pct) return hi + $urandom_range(1, 8);
    return $urandom_range(0, hi);
  endfunction

  task automatic build_sps(bit random_hdr);
    int unsigned profile, cf, smf, nlists, lsize, prev, nxt, poc, ncyc;
    int unsigned wb, hb, fmo, wpx, hpx, c0, c1;
    int d;
    int unsigned high_list[12] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134};
    if (random_hdr || $urandom_range(0, 99) < 4) put_bits($urandom_range(0, 255), 8);
    else put_bits({$urandom_range(0, 7), NAL_TYPE_SPS}, 8);
    profile = ($urandom_range(0, 1) != 0) ? high_list[$urandom_range(0, 11)]
                                          : $urandom_range(0, 255);
    put_bits(profile, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits($urandom_range(0, 255), 8);
    put_ue(pick_ue(31, 2));
    if (is_high_profile(profile)) begin
      cf = pick_ue(3, 2);
      put_ue(cf);
      if (cf == 3) put_bits($urandom_range(0, 1), 1);
      put_ue(pick_ue(6, 2));
      put_ue(pick_ue(6, 2));
      put_bits($urandom_range(0, 1), 1);
      smf = ($urandom_range(0, 2) == 0);
      put_bits(smf, 1);
      if (smf) begin
        nlists = (cf == 3) ? 12 : 8;
        for (int li = 0; li < nlists; li++) begin
          if ($urandom_range(0, 1) == 0) begin
            put_bits(0, 1);
          end else begin
            put_bits(1, 1);
            lsize = (li < 6) ? 16 : 64;
            prev = 8;
            for (int j = 0; j < lsize; j++) begin
              // sometimes end the list early by hitting a zero scale
              if ($urandom_range(0, 9) == 0) d = -int'(prev);
              else d = int'($urandom_range(0, 40)) - 20;
              put_se(d);
              nxt = (prev + d) & 8'hff;
              if (nxt == 0) break;
              prev = nxt;
            end
          end
        end
      end
    end
    put_ue(pick_ue(12, 2));
    poc = pick_ue(2, 2);
    put_ue(poc);
    if (poc == 0) put_ue(pick_ue(12, 2));
    else if (poc == 1) begin
      put_bits($urandom_range(0, 1), 1);
      put_se(int'($urandom_range(0, 200)) - 100);
      put_se(int'($urandom_range(0, 200)) - 100);
      ncyc = ($urandom_range(0, 30) == 0) ? MAX_CYCLE_REFS + 1 : $urandom_range(0, 4);
      put_ue(ncyc);
      if (ncyc <= MAX_CYCLE_REFS)
        for (int i = 0; i < ncyc; i++) put_se(int'($urandom_range(0, 64)) - 32);
    end
    put_ue(pick_ue(16, 2));
    put_bits($urandom_range(0, 1), 1);
    wb = ($urandom_range(0, 7) == 0) ? pick_ue(MAX_BLOCKS_DIM - 1, 10) : $urandom_range(0, 20);
    hb = ($urandom_range(0, 7) == 0) ? pick_ue(MAX_BLOCKS_DIM - 1, 10) : $urandom_range(0, 20);
    put_ue(wb);
    put_ue(hb);
    fmo = $urandom_range(0, 1);
    put_bits(fmo, 1);
    if (!fmo) put_bits($urandom_range(0, 1), 1);
    put_bits($urandom_range(0, 1), 1);
    if ($urandom_range(0, 1) == 0) begin
      put_bits(0, 1);
    end else begin
      put_bits(1, 1);
      wpx = (wb + 1) * 16;
      hpx = (2 - fmo) * (hb + 1) * 16;
      c0 = $urandom_range(0, wpx / 4);
      c1 = $urandom_range(0, wpx / 4);
      if ($urandom_range(0, 9) == 0) c1 = wpx / 2 - c0 + $urandom_range(0, 1);
      put_ue(c0 > CROP_LIMIT ? CROP_LIMIT : c0);
      put_ue(($urandom_range(0, 30) == 0) ? CROP_LIMIT + 1 : (c1 > CROP_LIMIT ? CROP_LIMIT : c1));
      c0 = $urandom_range(0, hpx / 4);
      c1 = $urandom_range(0, hpx / 4);
      if ($urandom_range(0, 9) == 0) c1 = hpx / 2 - c0 + $urandom_range(0, 1);
      put_ue(c0 > CROP_LIMIT ? CROP_LIMIT : c0);
      put_ue(c1 > CROP_LIMIT ? CROP_LIMIT : c1);
    end
    close_nal(($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0,
              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  task automatic build_directed();
    // empty NAL: header byte alone
    put_bits(8'h67, 8); nal_bits.delete();
    pending_bytes.push_back('{8'h67, 1'b1});
    // wrong NAL type
    pending_bytes.push_back('{8'h68, 1'b0});
    pending_bytes.push_back('{8'h42, 1'b1});
    // Exp-Golomb prefix too long for sps_id
    put_bits(8'h67, 8); put_bits(66, 8); put_bits(8'hff, 8); put_bits(8'h00, 8);
    put_bits(0, 32);
    close_nal(0, 0);
    // smallest baseline picture, no cropping
    put_bits(8'h67, 8); put_bits(66, 8); put_bits(0, 8); put_bits(0, 8);
    put_ue(0); put_ue(0); put_ue(2); put_ue(0); put_bits(0, 1);
    put_ue(0); put_ue(0); put_bits(1, 1); put_bits(0, 1); put_bits(0, 1);
    close_nal(0, 0);
    // largest picture, field coding, largest legal crop offsets
    put_bits(8'h67, 8); put_bits(100, 8); put_bits(8'hff, 8); put_bits(8'hff, 8);
    put_ue(31); put_ue(3); put_bits(1, 1); put_ue(6); put_ue(6); put_bits(1, 1);
    put_bits(0, 1); put_ue(12); put_ue(0); put_ue(12); put_ue(16); put_bits(1, 1);
    put_ue(MAX_BLOCKS_DIM - 1); put_ue(MAX_BLOCKS_DIM - 1); put_bits(0, 1);
    put_bits(1, 1); put_bits(1, 1); put_bits(1, 1);
    put_ue(CROP_LIMIT); put_ue(CROP_LIMIT); put_ue(CROP_LIMIT); put_ue(CROP_LIMIT);
    close_nal(0, 0);
    // crop wider than the picture
    put_bits(8'h67, 8); put_bits(77, 8); put_bits(0, 8); put_bits(30, 8);
    put_ue(1); put_ue(0); put_ue(2); put_ue(1); put_bits(0, 1);
    put_ue(0); put_ue(0); put_bits(1, 1); put_bits(0, 1); put_bits(1, 1);
    put_ue(5); put_ue(4); put_ue(0); put_ue(0);
    close_nal(0, 0);
    // all-ones and all-zeros noise
    pending_bytes.push_back('{8'hff, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b1});
    pending_bytes.push_back('{8'h00, 1'b0});
    pending_bytes.push_back('{8'h00, 1'b1});
  endtask

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  bit          stim_loaded;

  always @(posedge clk) begin
    if (!rst_n || !stim_loaded) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        predict_byte('{in_chan.byte_value, in_chan.last_byte});
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nal_byte_t nb;
          nb = pending_bytes.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.byte_value <= nb.byte_value;
          in_chan.last_byte  <= nb.last_byte;
          if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            in_gap = $urandom_range(1, 18);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sps_result_t got, want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.status, out_chan.profile_code, out_chan.constraint_flags,
                out_chan.level_code, out_chan.sps_id, out_chan.chroma_format,
                out_chan.luma_bit_depth, out_chan.chroma_bit_depth,
                out_chan.log2_max_frame_num, out_chan.ref_frame_count,
                out_chan.frame_width, out_chan.frame_height};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
          out_stall = $urandom_range(1, 18);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    in_chan.valid = 1'b0;
    in_chan.byte_value = '0;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
    rst_n = 1'b0;
    in_gap = 0;
    out_stall = 0;
    cycle_count = 0;
    mismatch_count = 0;
    stim_loaded = 1'b0;
    sps_clear();
    build_directed();
    while (pending_bytes.size() < 650) build_sps($urandom_range(0, 19) == 0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    stim_loaded = 1'b1;
    while (pending_bytes.size() > 0 || in_chan.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
